### sv/haplotype_flank_variant_count_macros.svh
// Assertion macros shared by the flank variant counter modules.
// No dependencies.
`ifndef HAPLOTYPE_FLANK_VARIANT_COUNT_MACROS_SVH
`define HAPLOTYPE_FLANK_VARIANT_COUNT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define HFVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication with the consequent checked in the cycle after the antecedent
`define HFVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### sv/hfvc_pkg.sv
// Shared types and constants for the flank variant counter.
// No dependencies.
package hfvc_pkg;
	localparam int MaxEntries = 1024;
	localparam int Haplotypes = 2;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = IdxW + 1;
	localparam int HapW = (Haplotypes > 1) ? $clog2(Haplotypes) : 1;
	localparam int AddrW = HapW + IdxW;
	localparam int DistW = 12;
	localparam logic [DistW-1:0] DistMax = '1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_CHK,
		ST_HAP_INIT,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_PREV_RD,
		ST_PREV_CHK,
		ST_FWD_RD,
		ST_FWD_CHK,
		ST_BWD_RD,
		ST_BWD_CHK,
		ST_HAP_DONE,
		ST_RESULT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic latch_in;     // capture input item
		logic clear;        // zero all counts
		logic app_rd;       // read last record of target table
		logic app_wr;       // write record if legal
		logic hap_init;     // set up search for current haplotype
		logic srch_rd;      // read mid record
		logic srch_step;    // narrow search range
		logic prev_rd;      // read record before start
		logic prev_chk;     // validity check
		logic fwd_init;
		logic fwd_rd;
		logic fwd_step;
		logic bwd_init;
		logic bwd_rd;
		logic bwd_step;
		logic hap_done;     // fold haplotype count into best
		logic res_init;
		logic result;       // present result
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		opcode_t op;
		logic    hap_empty;
		logic    srch_done;
		logic    start_zero;
		logic    prev_bad;
		logic    fwd_more;
		logic    fwd_hit;
		logic    bwd_more;
		logic    bwd_hit;
		logic    last_hap;
	} status_t;
endpackage

### sv/hfvc_ctrl.sv
// Controller state machine for the flank variant counter.
// Depends on hfvc_pkg and the assertion macro header.
`include "haplotype_flank_variant_count_macros.svh"
module hfvc_ctrl import hfvc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t st,
	output cmd_t    cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch_in = 1'b1;
					state_nx = ST_APP_RD;
				end
			end
			ST_APP_RD: begin
				// dispatch on latched opcode
				unique case (st.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_nx = ST_IDLE;
					end
					OP_APPEND: begin
						cmd.app_rd = 1'b1;
						state_nx = ST_APP_CHK;
					end
					OP_QUERY: begin
						cmd.res_init = 1'b1;
						state_nx = ST_HAP_INIT;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_APP_CHK: begin
				cmd.app_wr = 1'b1;
				state_nx = ST_IDLE;
			end
			ST_HAP_INIT: begin
				cmd.hap_init = 1'b1;
				state_nx = ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				if (st.hap_empty) state_nx = ST_HAP_DONE;
				else if (st.srch_done) begin
					if (st.start_zero) begin
						cmd.fwd_init = 1'b1;
						state_nx = ST_FWD_RD;
					end else begin
						cmd.prev_rd = 1'b1;
						state_nx = ST_PREV_CHK;
					end
				end else begin
					cmd.srch_rd = 1'b1;
					state_nx = ST_SRCH_CHK;
				end
			end
			ST_SRCH_CHK: begin
				cmd.srch_step = 1'b1;
				state_nx = ST_SRCH_RD;
			end
			ST_PREV_RD: state_nx = ST_PREV_CHK;
			ST_PREV_CHK: begin
				cmd.prev_chk = 1'b1;
				if (st.prev_bad) state_nx = ST_HAP_DONE;
				else begin
					cmd.fwd_init = 1'b1;
					state_nx = ST_FWD_RD;
				end
			end
			ST_FWD_RD: begin
				if (st.fwd_more) begin
					cmd.fwd_rd = 1'b1;
					state_nx = ST_FWD_CHK;
				end else begin
					cmd.bwd_init = 1'b1;
					state_nx = ST_BWD_RD;
				end
			end
			ST_FWD_CHK: begin
				if (st.fwd_hit) begin
					cmd.fwd_step = 1'b1;
					state_nx = ST_FWD_RD;
				end else begin
					cmd.bwd_init = 1'b1;
					state_nx = ST_BWD_RD;
				end
			end
			ST_BWD_RD: begin
				if (st.bwd_more) begin
					cmd.bwd_rd = 1'b1;
					state_nx = ST_BWD_CHK;
				end else state_nx = ST_HAP_DONE;
			end
			ST_BWD_CHK: begin
				if (st.bwd_hit) begin
					cmd.bwd_step = 1'b1;
					state_nx = ST_BWD_RD;
				end else state_nx = ST_HAP_DONE;
			end
			ST_HAP_DONE: begin
				cmd.hap_done = 1'b1;
				state_nx = st.last_hap ? ST_RESULT : ST_HAP_INIT;
			end
			ST_RESULT: begin
				cmd.result = 1'b1;
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	`HFVC_ASSERT_IMP(a_busy_idle, clk, arst_n, state_q == ST_IDLE, !busy)
	`HFVC_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n,
		state_q == ST_IDLE && start, state_q == ST_APP_RD)
	`HFVC_ASSERT_NEXT(a_result_to_idle, clk, arst_n, cmd.result, state_q == ST_IDLE)
endmodule

### sv/hfvc_datapath.sv
// Datapath for the flank variant counter: record memory, counts, search and walks.
// Depends on hfvc_pkg and the assertion macro header.
`include "haplotype_flank_variant_count_macros.svh"
module hfvc_datapath import hfvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [1:0]        opcode,
	input  logic              haplotype,
	input  logic [31:0]       position,
	input  logic [15:0]       ref_length,
	input  logic [15:0]       alt_length,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic [DistW-1:0]  max_distance,
	output logic              distance_valid,
	output logic              done
);
	logic [63:0] mem [Haplotypes*MaxEntries];
	logic [63:0] rd_q;
	logic [CntW-1:0] count_q [Haplotypes];
	logic [15:0] rlen_q;

	opcode_t     op_q;
	logic        hin_q;
	logic [31:0] pos_q;
	logic [15:0] ref_q, alt_q;

	logic [HapW-1:0] hap_q;
	logic [CntW-1:0] lo_q, hi_q, fj_q, bj_q;
	logic [CntW-1:0] n_cur;
	logic [CntW-1:0] mid;
	logic [48:0] flank_q;
	logic [32:0] edge_q;
	logic [CntW-1:0] cnt_q;
	logic        hvalid_q;
	logic [DistW-1:0] best_q;
	logic        any_q;
	logic        res_q;
	logic [DistW-1:0] res_d_q;
	logic        res_v_q;

	logic        rd_en;
	logic [AddrW-1:0] rd_addr;
	logic [HapW-1:0] app_h;
	logic        app_ok;
	logic [32:0] rd_end;
	logic [48:0] fwd_f, bwd_f;

	assign n_cur = count_q[hap_q];
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_end = {1'b0, rd_q[31:0]} + {17'd0, rd_q[47:32]};
	assign app_h = HapW'(hin_q);

	// forward gap: record start minus edge; backward: edge minus record end
	assign fwd_f = flank_q + 49'({1'b0, rd_q[31:0]} - edge_q);
	assign bwd_f = flank_q + 49'(edge_q - rd_end);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (cmd.app_rd) begin
			rd_en = 1'b1;
			rd_addr = {app_h, IdxW'(count_q[app_h] - 1'b1)};
		end else if (cmd.srch_rd) begin
			rd_en = 1'b1;
			rd_addr = {hap_q, mid[IdxW-1:0]};
		end else if (cmd.prev_rd) begin
			rd_en = 1'b1;
			rd_addr = {hap_q, IdxW'(lo_q - 1'b1)};
		end else if (cmd.fwd_rd) begin
			rd_en = 1'b1;
			rd_addr = {hap_q, fj_q[IdxW-1:0]};
		end else if (cmd.bwd_rd) begin
			rd_en = 1'b1;
			rd_addr = {hap_q, IdxW'(bj_q - 1'b1)};
		end
	end

	assign app_ok = (int'(hin_q) < Haplotypes) &&
		(count_q[app_h] < CntW'(MaxEntries)) &&
		((count_q[app_h] == '0) || ({1'b0, pos_q} >= rd_end));

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
		if (cmd.app_wr && app_ok)
			mem[{app_h, count_q[app_h][IdxW-1:0]}] <= {alt_q, ref_q, pos_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= opcode_t'(opcode);
			hin_q <= haplotype;
			pos_q <= position;
			ref_q <= ref_length;
			alt_q <= alt_length;
		end
		if (cmd.res_init) hap_q <= '0;
		else if (cmd.hap_done) hap_q <= hap_q + 1'b1;
		if (cmd.hap_init) begin
			lo_q <= '0;
			hi_q <= n_cur;
			cnt_q <= '0;
			hvalid_q <= 1'b1;
		end
		if (cmd.srch_step) begin
			if ({1'b0, rd_q[31:0]} < {1'b0, pos_q}) lo_q <= mid + 1'b1;
			else hi_q <= mid;
		end
		if (cmd.prev_chk && st.prev_bad) hvalid_q <= 1'b0;
		if (cmd.fwd_init) begin
			fj_q <= lo_q;
			flank_q <= '0;
			edge_q <= {1'b0, pos_q};
		end
		if (cmd.fwd_step) begin
			fj_q <= fj_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
			flank_q <= fwd_f + 49'(rd_q[63:48]);
			edge_q <= rd_end;
		end
		if (cmd.bwd_init) begin
			bj_q <= lo_q;
			flank_q <= 49'd1;
			edge_q <= {1'b0, pos_q};
		end
		if (cmd.bwd_step) begin
			bj_q <= bj_q - 1'b1;
			cnt_q <= cnt_q + 1'b1;
			flank_q <= bwd_f + 49'(rd_q[63:48]);
			edge_q <= {1'b0, rd_q[31:0]};
		end
		if (cmd.result) begin
			res_d_q <= any_q ? best_q : '0;
			res_v_q <= any_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Haplotypes; i++) count_q[i] <= '0;
			rlen_q <= 16'd150;
			best_q <= '0;
			any_q <= 1'b0;
			res_q <= 1'b0;
		end else begin
			if (cfg_we) rlen_q <= cfg_wdata;
			if (cmd.clear) for (int i = 0; i < Haplotypes; i++) count_q[i] <= '0;
			if (cmd.app_wr && app_ok) count_q[app_h] <= count_q[app_h] + 1'b1;
			if (cmd.res_init) begin
				best_q <= '0;
				any_q <= 1'b0;
			end
			if (cmd.hap_done && hvalid_q) begin
				any_q <= 1'b1;
				if (DistW'(cnt_q) > best_q) best_q <= DistW'(cnt_q);
			end
			res_q <= cmd.result;
		end
	end

	assign st.op = op_q;
	assign st.hap_empty = (n_cur == '0);
	assign st.srch_done = (lo_q >= hi_q);
	assign st.start_zero = (lo_q == '0);
	assign st.prev_bad = ({1'b0, pos_q} < rd_end);
	assign st.fwd_more = (fj_q < n_cur);
	assign st.fwd_hit = (fwd_f < 49'(rlen_q));
	assign st.bwd_more = (bj_q != '0);
	assign st.bwd_hit = (bwd_f < 49'(rlen_q));
	assign st.last_hap = (int'(hap_q) == Haplotypes - 1);

	assign max_distance = res_d_q;
	assign distance_valid = res_v_q;
	assign done = res_q;

	`HFVC_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q[0] <= CntW'(MaxEntries))
	`HFVC_ASSERT_IMP(a_search_range, clk, arst_n, cmd.srch_step, lo_q < hi_q)
	`HFVC_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
endmodule

### sv/haplotype_flank_variant_count.sv
// Top level of the flank variant counter: joins controller and datapath.
// Depends on hfvc_pkg, hfvc_ctrl and hfvc_datapath.
// One item is taken when start is high and busy low. A query runs, per
// haplotype, a binary search and then forward and backward walks over
// the records it counts, skipped when its table is empty. Its result
// appears on max_distance/distance_valid for one cycle with done high,
// in the first idle cycle, and cannot be held off. The search and walk
// lengths through the record memory set the query time.
module haplotype_flank_variant_count import hfvc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic              haplotype,
	input  logic [31:0]       position,
	input  logic [15:0]       ref_length,
	input  logic [15:0]       alt_length,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic              done,
	output logic [DistW-1:0]  max_distance,
	output logic              distance_valid
);
	cmd_t    cmd;
	status_t st;

	hfvc_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .st, .cmd
	);

	hfvc_datapath u_dp (
		.clk, .arst_n, .cmd, .st, .opcode, .haplotype, .position,
		.ref_length, .alt_length, .cfg_we, .cfg_wdata,
		.max_distance, .distance_valid, .done
	);
endmodule

### tb/tb_haplotype_flank_variant_count.sv
// Self-checking testbench for haplotype_flank_variant_count: predicts every query result.
// Depends on hfvc_pkg and the RTL of the block only.
module tb_haplotype_flank_variant_count;
	import hfvc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		opcode_t     op;
		logic        hap;
		logic [31:0] pos;
		logic [15:0] rlen;
		logic [15:0] alen;
	} item_t;

	typedef struct {
		logic [DistW-1:0] cnt;
		logic             valid;
	} dist_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        opcode = 2'd0;
	logic              haplotype = 1'b0;
	logic [31:0]       position = '0;
	logic [15:0]       ref_length = '0;
	logic [15:0]       alt_length = '0;
	logic              cfg_we = 1'b0;
	logic [15:0]       cfg_wdata = '0;
	logic              done;
	logic [DistW-1:0]  max_distance;
	logic              distance_valid;

	haplotype_flank_variant_count uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .haplotype(haplotype), .position(position),
		.ref_length(ref_length), .alt_length(alt_length),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.max_distance(max_distance), .distance_valid(distance_valid)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [31:0] tab_pos [Haplotypes][MaxEntries];
	logic [15:0] tab_ref [Haplotypes][MaxEntries];
	logic [15:0] tab_alt [Haplotypes][MaxEntries];
	int unsigned tab_cnt [Haplotypes];
	logic [15:0] window = 16'd150;

	item_t pending_items[$];
	dist_t expected_dists[$];
	item_t cur_item;
	bit    steady = 0;
	int    errors = 0;
	int    n_queries = 0, n_invalid = 0, n_counted = 0;

	function automatic logic [63:0] rec_end(int h, int i);
		return 64'(tab_pos[h][i]) + 64'(tab_ref[h][i]);
	endfunction

	// returns 0 if the query falls inside a record of haplotype h
	function automatic bit flank_total(int h, logic [31:0] q, output logic [63:0] total);
		int unsigned lo, hi, mid, n, j;
		logic [63:0] edge_p, flank;
		total = 0;
		n = tab_cnt[h];
		if (n == 0) return 1;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tab_pos[h][mid] < q) lo = mid + 1;
			else hi = mid;
		end
		if (lo > 0 && 64'(q) < rec_end(h, lo - 1)) return 0;
		edge_p = 64'(q);
		flank = 0;
		for (j = lo; j < n; j++) begin
			flank += 64'(tab_pos[h][j]) - edge_p;
			if (flank >= 64'(window)) break;
			total++;
			flank += 64'(tab_alt[h][j]);
			edge_p = rec_end(h, j);
		end
		edge_p = 64'(q);
		flank = 1;
		for (j = lo; j > 0; j--) begin
			flank += edge_p - rec_end(h, j - 1);
			if (flank >= 64'(window)) break;
			total++;
			flank += 64'(tab_alt[h][j - 1]);
			edge_p = 64'(tab_pos[h][j - 1]);
		end
		return 1;
	endfunction

	task automatic apply_item(item_t it);
		logic [63:0] best, c;
		bit any;
		dist_t d;
		int n;
		case (it.op)
			OP_CLEAR: for (int h = 0; h < Haplotypes; h++) tab_cnt[h] = 0;
			OP_APPEND: begin
				n = tab_cnt[it.hap];
				if (n < MaxEntries && (n == 0 || 64'(it.pos) >= rec_end(it.hap, n - 1))) begin
					tab_pos[it.hap][n] = it.pos;
					tab_ref[it.hap][n] = it.rlen;
					tab_alt[it.hap][n] = it.alen;
					tab_cnt[it.hap] = n + 1;
				end
			end
			OP_QUERY: begin
				best = 0;
				any = 0;
				for (int h = 0; h < Haplotypes; h++)
					if (flank_total(h, it.pos, c)) begin
						any = 1;
						if (c > best) best = c;
					end
				if (best > 64'(DistMax)) best = 64'(DistMax);
				d.cnt = any ? best[DistW-1:0] : '0;
				d.valid = any;
				expected_dists = {expected_dists, d};
				n_queries++;
				if (!any) n_invalid++;
				if (best != 0) n_counted++;
			end
			default: ;
		endcase
	endtask

	// driver: one transfer per edge with start high and busy low
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) apply_item(cur_item);
			if (!start || !busy) begin
				if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
					cur_item = pending_items.pop_front();
					start <= 1'b1;
					opcode <= cur_item.op;
					haplotype <= cur_item.hap;
					position <= cur_item.pos;
					ref_length <= cur_item.rlen;
					alt_length <= cur_item.alen;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		dist_t e;
		if (arst_n && done) begin
			if (expected_dists.size() == 0) begin
				$display("%0t: unexpected result count=%0d valid=%0b", $time,
					max_distance, distance_valid);
				errors++;
			end else begin
				e = expected_dists.pop_front();
				if (max_distance !== e.cnt) begin
					$display("%0t: max_distance expected %0d actual %0d", $time,
						e.cnt, max_distance);
					errors++;
				end
				if (distance_valid !== e.valid) begin
					$display("%0t: distance_valid expected %0b actual %0b", $time,
						e.valid, distance_valid);
					errors++;
				end
			end
		end
	end

	task automatic push_item(opcode_t op, logic hap, logic [31:0] pos,
			logic [15:0] rl, logic [15:0] al);
		item_t it;
		it.op = op;
		it.hap = hap;
		it.pos = pos;
		it.rlen = rl;
		it.alen = al;
		pending_items = {pending_items, it};
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_dists.size() > 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_window(logic [15:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		window = v;
		@(posedge clk);
	endtask

	// random phase: mostly ordered record runs followed by queries near them
	task automatic random_phase(int n_items);
		logic [63:0] cur [Haplotypes];
		logic [63:0] base;
		int produced, k;
		logic h;
		produced = 0;
		while (produced < n_items) begin
			push_item(OP_CLEAR, $urandom_range(1), $urandom, $urandom, $urandom);
			base = $urandom_range(3) == 0 ? 64'($urandom) : 64'($urandom_range(5000));
			for (int i = 0; i < Haplotypes; i++) cur[i] = base;
			k = $urandom_range(1, 24);
			for (int i = 0; i < k; i++) begin
				h = $urandom_range(1);
				cur[h] += $urandom_range(0, (window > 60 || window == 0) ? 60 : window);
				push_item(OP_APPEND, h, cur[h][31:0], $urandom_range(0, 12),
					$urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20)));
				cur[h] += 64'(pending_items[$].rlen);
			end
			k = $urandom_range(2, 8);
			for (int i = 0; i < k; i++)
				push_item(OP_QUERY, $urandom_range(1),
					32'(base + $urandom_range(0, 64'(cur[0] > cur[1] ? cur[0] : cur[1]) - base + 20)),
					$urandom, $urandom);
			// noise
			k = $urandom_range(0, 3);
			for (int i = 0; i < k; i++)
				push_item(opcode_t'($urandom_range(1, 3)), $urandom_range(1), $urandom,
					$urandom, $urandom);
			produced = produced + pending_items.size();
			while (pending_items.size() > 0) @(posedge clk);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tables, overlap, ignored appends, field extremes, invalid cases
		push_item(OP_CLEAR, 0, 0, 0, 0);
		push_item(OP_QUERY, 0, 32'd0, 0, 0);
		push_item(OP_APPEND, 0, 32'd100, 16'd10, 16'd5);
		push_item(OP_APPEND, 0, 32'd105, 16'd1, 16'd1);
		push_item(OP_APPEND, 0, 32'd110, 16'd0, 16'hFFFF);
		push_item(OP_APPEND, 0, 32'd200, 16'hFFFF, 16'd0);
		push_item(OP_APPEND, 1, 32'd0, 16'd0, 16'd0);
		push_item(OP_APPEND, 1, 32'hFFFF0000, 16'hFFFF, 16'hFFFF);
		push_item(OP_NONE, 1, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
		push_item(OP_QUERY, 1, 32'd105, 16'hFFFF, 16'hFFFF);
		push_item(OP_QUERY, 0, 32'd0, 0, 0);
		push_item(OP_QUERY, 0, 32'd100, 0, 0);
		push_item(OP_QUERY, 0, 32'hFFFFFFFF, 0, 0);
		push_item(OP_QUERY, 0, 32'd150, 0, 0);
		push_item(OP_QUERY, 0, 32'd300, 0, 0);
		push_item(OP_CLEAR, 1, 0, 0, 0);
		push_item(OP_APPEND, 0, 32'd200, 16'd300, 16'd0);
		push_item(OP_APPEND, 1, 32'd250, 16'd100, 16'd3);
		push_item(OP_QUERY, 0, 32'd300, 0, 0);
		push_item(OP_QUERY, 0, 32'd600, 0, 0);
		random_phase(60);

		set_window(16'd1);
		random_phase(50);
		set_window(16'd65535);
		random_phase(60);
		set_window(16'd0);
		random_phase(30);
		set_window(16'd20);
		steady = 1;
		random_phase(60);
		steady = 0;

		// fill one table past its depth
		set_window(16'd3);
		push_item(OP_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < MaxEntries + 6; i++)
			push_item(OP_APPEND, 1, 32'(1000 + 2 * i), 16'd1, 16'd0);
		push_item(OP_QUERY, 0, 32'd1000, 0, 0);
		push_item(OP_QUERY, 0, 32'(1000 + 2 * MaxEntries - 2), 0, 0);
		push_item(OP_QUERY, 0, 32'(1000 + 2 * MaxEntries + 4), 0, 0);
		push_item(OP_QUERY, 0, 32'd1001, 0, 0);

		set_window(16'($urandom_range(2, 400)));
		random_phase(50);
		set_window(16'($urandom_range(1, 65535)));
		random_phase(40);
		drain();

		$display("covered %0d queries: %0d with no valid haplotype, %0d with nonzero count",
			n_queries, n_invalid, n_counted);
		if (errors == 0) begin
			$display("tb_haplotype_flank_variant_count: done, clean");
		end else begin
			$display("tb_haplotype_flank_variant_count: done, errors");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("tb_haplotype_flank_variant_count: done, errors");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/hfvc_pkg.sv
sv/hfvc_ctrl.sv
sv/hfvc_datapath.sv
sv/haplotype_flank_variant_count.sv
tb/tb_haplotype_flank_variant_count.sv
